### design/crtt_pkg.sv
// Shared types and constants of the call/return trace table.
`default_nettype none
package crtt_pkg;

  localparam int ENTRIES_DEF   = 4096;
  localparam int MAX_DEPTH_DEF = 255;

  localparam int FUNC_W      = 2;
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 31;
  localparam int STATUS_W    = 3;
  localparam int INDEX_W     = 12;
  localparam int DEPTH_OUT_W = 8;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 88;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CALL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RET  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ADDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CALL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RET   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS  = 3'd4;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_CALL,
    KIND_RET,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] target;
    logic [LEN_W-1:0]  length;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [INDEX_W-1:0]     entry_index;
    logic [DEPTH_OUT_W-1:0] depth_before;
    logic [ADDR_W-1:0]      entry_start;
    logic [ADDR_W-1:0]      pc_out;
  } result_t;

endpackage
`default_nettype wire

### design/crtt_front.sv
// Input side: takes beats and classifies them into commands for the queue.
`default_nettype none
module crtt_front (
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [crtt_pkg::FUNC_W-1:0]    s_axis_tuser,
  input  wire logic [crtt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                           full,
  output logic                                push,
  output crtt_pkg::cmd_t                      cmd
);
  import crtt_pkg::*;

  kind_t kind;

  always_comb begin
    unique case (s_axis_tuser)
      FUNC_ADD:  kind = KIND_ADD;
      FUNC_CALL: kind = KIND_CALL;
      FUNC_RET:  kind = KIND_RET;
      FUNC_NONE: kind = KIND_NOP;
    endcase
  end

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  assign cmd.kind   = kind;
  assign cmd.pc     = s_axis_tdata[31:0];
  assign cmd.target = s_axis_tdata[63:32];
  assign cmd.length = s_axis_tdata[94:64];

endmodule
`default_nettype wire

### design/crtt_queue.sv
// Short command queue between the front and the lookup engine.
`default_nettype none
module crtt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire crtt_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output crtt_pkg::cmd_t      head
);
  import crtt_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_pop;

  assign full   = fill == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign valid  = fill != '0;
  assign head   = slots[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### design/crtt_back.sv
// Lookup engine: entry tables, sequential scan, depth tracking, result register.
`default_nettype none
module crtt_back #(
  parameter int ENTRIES   = crtt_pkg::ENTRIES_DEF,
  parameter int MAX_DEPTH = crtt_pkg::MAX_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire crtt_pkg::cmd_t q_cmd,
  output logic            pop,
  output logic            m_valid,
  input  wire logic       m_ready,
  output crtt_pkg::result_t m_res
);
  import crtt_pkg::*;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state;
  logic [CNT_W-1:0]   count;
  logic [DEPTH_W-1:0] depth;
  cmd_t               cur;
  result_t            res;

  logic [ADDR_W-1:0]  start_mem [ENTRIES];
  logic [LEN_W-1:0]   len_mem   [ENTRIES];

  logic [CNT_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   rd_idx;
  logic               rd_valid;
  logic [ADDR_W-1:0]  rd_start;
  logic [LEN_W-1:0]   rd_len;

  logic               tbl_full;
  logic               we;
  logic               issue;
  logic [ADDR_W-1:0]  diff;
  logic               call_hit;
  logic               ret_hit;
  logic               hit;
  logic               last;
  logic               emit;

  assign tbl_full = count == CNT_W'(ENTRIES);
  assign pop      = (state == S_IDLE) && q_valid;
  assign we       = pop && (q_cmd.kind == KIND_ADD) && !tbl_full;
  assign issue    = (state == S_SCAN) && (rd_addr < count);
  assign emit     = (state == S_EMIT) && (!m_valid || m_ready);

  assign diff     = cur.pc - rd_start;
  assign call_hit = rd_start == cur.target;
  assign ret_hit  = (diff != '0) && !diff[ADDR_W-1] && (diff[LEN_W-1:0] <= rd_len);
  assign hit      = (state == S_SCAN) && rd_valid &&
                    ((cur.kind == KIND_CALL) ? call_hit : ret_hit);
  assign last     = (state == S_SCAN) && rd_valid && (CNT_W'(rd_idx + 1'b1) == count);

  always_ff @(posedge clk) begin
    if (we) begin
      start_mem[count[IDX_W-1:0]] <= q_cmd.target;
      len_mem[count[IDX_W-1:0]]   <= q_cmd.length;
    end
    rd_start <= start_mem[rd_addr[IDX_W-1:0]];
    rd_len   <= len_mem[rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      depth    <= '0;
      rd_valid <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      rd_valid <= issue && !hit && !last;
      rd_idx   <= rd_addr;
      if (issue) rd_addr <= rd_addr + 1'b1;
      if (emit) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur              <= q_cmd;
            rd_addr          <= '0;
            res.depth_before <= DEPTH_OUT_W'(depth);
            res.pc_out       <= q_cmd.pc;
            unique case (q_cmd.kind)
              KIND_ADD: begin
                res.entry_start <= q_cmd.target;
                state           <= S_EMIT;
                if (tbl_full) begin
                  res.status      <= ST_FULL;
                  res.entry_index <= '0;
                end else begin
                  res.status      <= ST_ADDED;
                  res.entry_index <= INDEX_W'(count);
                  count           <= count + 1'b1;
                end
              end
              KIND_CALL, KIND_RET, KIND_NOP: begin
                res.status      <= ST_MISS;
                res.entry_index <= '0;
                res.entry_start <= '0;
                state           <= ((q_cmd.kind != KIND_NOP) && (count != '0)) ?
                                   S_SCAN : S_EMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            res.entry_index <= INDEX_W'(rd_idx);
            res.entry_start <= rd_start;
            state           <= S_EMIT;
            if (cur.kind == KIND_CALL) begin
              res.status <= ST_CALL;
              if (depth < DEPTH_W'(MAX_DEPTH)) depth <= depth + 1'b1;
            end else begin
              res.status <= ST_RET;
              if (depth != '0) depth <= depth - 1'b1;
            end
          end else if (last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            m_res <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/call_return_trace_table.sv
// Top level of the function call/return trace table.
//
// Input stream s_axis: tuser carries the item kind (add entry, call, return, none);
// tdata carries pc, target address and entry length. Output stream m_axis:
// tuser carries the status, tdata the entry index, depth before the event,
// entry start and the echoed pc. One result beat per input beat, in order.
// A front stage classifies beats into a four-deep command queue; the back
// engine pops one command at a time and scans the entry table held in a
// memory, one entry per cycle with a registered read.
// Add and unused kinds go straight to the result; call and return scan the
// entries held, ending early when a match is found, and the next command is
// popped only after the result of the last one has been passed on.
// Reset clears the entry count, the call depth, the queue and the output valid;
// table contents are not cleared, only entries below the count are read.
// When the receiver stalls, the result holds in the output register, the
// engine waits with the next result, and the queue keeps taking beats until
// it fills, after which s_axis_tready drops.
`default_nettype none
module call_return_trace_table #(
  parameter int ENTRIES   = crtt_pkg::ENTRIES_DEF,
  parameter int MAX_DEPTH = crtt_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // func
  input  wire logic [crtt_pkg::FUNC_W-1:0]     s_axis_tuser,
  // pc, target_addr, entry_length, zero pad
  input  wire logic [crtt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status
  output logic [crtt_pkg::STATUS_W-1:0]        m_axis_tuser,
  // entry_index, depth_before, entry_start, pc_out, zero pad
  output logic [crtt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import crtt_pkg::*;

  logic    full;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  logic    q_valid;
  cmd_t    q_cmd;
  result_t m_res;

  crtt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .full          (full),
    .push          (push),
    .cmd           (push_cmd)
  );

  crtt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_cmd)
  );

  crtt_back #(
    .ENTRIES   (ENTRIES),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_res   (m_res)
  );

  assign m_axis_tuser = m_res.status;
  assign m_axis_tdata = {4'b0, m_res.pc_out, m_res.entry_start,
                         m_res.depth_before, m_res.entry_index};

endmodule
`default_nettype wire

### design/crtt_checker.sv
// Port-level checks of the trace table, bound to the top level.
`default_nettype none
module crtt_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [crtt_pkg::FUNC_W-1:0]     s_axis_tuser,
  input wire logic [crtt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [crtt_pkg::STATUS_W-1:0]   m_axis_tuser,
  input wire logic [crtt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import crtt_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tuser) && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_MISS) |->
      (m_axis_tdata[11:0] == '0) && (m_axis_tdata[51:20] == '0))
    else $error("miss result carries an entry");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> m_axis_tdata[11:0] == '0)
    else $error("table full result carries an index");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_ADDED) || (m_axis_tuser == ST_FULL) ||
      (m_axis_tuser == ST_CALL) || (m_axis_tuser == ST_RET) ||
      (m_axis_tuser == ST_MISS))
    else $error("undefined status code");

endmodule

bind call_return_trace_table crtt_checker u_crtt_checker (.*);
`default_nettype wire

### verif/call_return_trace_table_tb.sv
// Self-checking testbench for the call/return trace table.
module call_return_trace_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crtt_pkg::*;

  typedef struct packed {
    kind_t                  kind;
    logic [ADDR_W-1:0]      pc;
    logic [ADDR_W-1:0]      target;
    logic [LEN_W-1:0]       length;
    logic                   typed;
    logic [STATUS_W-1:0]    status;
    logic [INDEX_W-1:0]     index;
    logic [DEPTH_OUT_W-1:0] depth;
    logic [ADDR_W-1:0]      start;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;

  // rows with typed set carry their expected result; the rest go to the predictor
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{KIND_CALL, 32'hFFFF_FFFF, 32'h0000_1000, 31'h0, 1'b1, ST_MISS, 12'd0, 8'd0, 32'h0},
    '{KIND_RET,  32'h0000_0000, 32'h0000_0000, 31'h0, 1'b1, ST_MISS, 12'd0, 8'd0, 32'h0},
    '{KIND_NOP,  32'hDEAD_BEEF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, ST_MISS, 12'd0, 8'd0, 32'h0},
    '{KIND_ADD,  32'h0000_0100, 32'h0000_0000, 31'h0, 1'b1, ST_ADDED, 12'd0, 8'd0, 32'h0},
    '{KIND_ADD,  32'h0000_0104, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, ST_ADDED, 12'd1, 8'd0,
      32'hFFFF_FFFF},
    '{KIND_ADD,  32'h0000_0108, 32'h8000_0000, 31'h10, 1'b1, ST_ADDED, 12'd2, 8'd0,
      32'h8000_0000},
    '{KIND_ADD,  32'h0000_010C, 32'h8000_0000, 31'h100, 1'b1, ST_ADDED, 12'd3, 8'd0,
      32'h8000_0000},
    '{KIND_CALL, 32'h0000_1000, 32'h8000_0000, 31'h0, 1'b1, ST_CALL, 12'd2, 8'd0,
      32'h8000_0000},
    '{KIND_CALL, 32'h8000_0004, 32'h0000_0000, 31'h0, 1'b1, ST_CALL, 12'd0, 8'd1, 32'h0},
    '{KIND_RET,  32'h8000_0000, 32'h0000_0000, 31'h0, 1'b1, ST_MISS, 12'd0, 8'd2, 32'h0},
    '{KIND_RET,  32'h8000_0010, 32'h0000_0000, 31'h0, 1'b1, ST_RET, 12'd2, 8'd2,
      32'h8000_0000},
    '{KIND_RET,  32'h8000_0011, 32'h0000_0000, 31'h0, 1'b1, ST_RET, 12'd3, 8'd1,
      32'h8000_0000},
    '{KIND_RET,  32'h7FFF_FFFE, 32'h0000_0000, 31'h0, 1'b1, ST_RET, 12'd1, 8'd0,
      32'hFFFF_FFFF},
    '{KIND_RET,  32'h7FFF_FFFF, 32'h0000_0000, 31'h0, 1'b1, ST_MISS, 12'd0, 8'd0, 32'h0},
    '{KIND_RET,  32'h0000_0000, 32'h0000_0000, 31'h0, 1'b1, ST_RET, 12'd1, 8'd0,
      32'hFFFF_FFFF},
    '{KIND_CALL, 32'h0000_0010, 32'hFFFF_FFFF, 31'h0, 1'b1, ST_CALL, 12'd1, 8'd0,
      32'hFFFF_FFFF},
    '{KIND_CALL, 32'h0000_0020, 32'h1234_5678, 31'h0, 1'b1, ST_MISS, 12'd0, 8'd1, 32'h0},
    '{KIND_ADD,  32'h0000_0000, 32'h5555_5555, 31'h2AAA_AAAA, 1'b1, ST_ADDED, 12'd4, 8'd1,
      32'h5555_5555},
    '{KIND_ADD,  32'h0000_0000, 32'hAAAA_AAAA, 31'h5555_5555, 1'b1, ST_ADDED, 12'd5, 8'd1,
      32'hAAAA_AAAA},
    '{KIND_CALL, 32'h4000_0000, 32'hAAAA_AAAA, 31'h0, 1'b0, ST_MISS, 12'd0, 8'd0, 32'h0},
    '{KIND_RET,  32'hAAAA_AAAB, 32'h0000_0000, 31'h0, 1'b0, ST_MISS, 12'd0, 8'd0, 32'h0},
    '{KIND_NOP,  32'h1234_5678, 32'h5555_5555, 31'h2AAA_AAAA, 1'b1, ST_MISS, 12'd0, 8'd1, 32'h0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [FUNC_W-1:0]      s_axis_tuser = '0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [ADDR_W-1:0] fn_start [ENTRIES_DEF];
  logic [LEN_W-1:0]  fn_len [ENTRIES_DEF];
  int                fn_count = 0;
  int                call_level = 0;

  result_t pending_traces [$];
  int      results_seen = 0;
  int      fault_count = 0;
  bit      src_calm = 1'b0;
  bit      snk_calm = 1'b0;
  bit      hold_done = 1'b0;

  call_return_trace_table dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t trace_event(kind_t kind, logic [ADDR_W-1:0] pc,
                                          logic [ADDR_W-1:0] target, logic [LEN_W-1:0] len);
    result_t          r;
    logic [ADDR_W-1:0] d;
    int               hit;
    r = '{status: ST_MISS, entry_index: '0, depth_before: 8'(call_level),
          entry_start: '0, pc_out: pc};
    hit = -1;
    case (kind)
      KIND_ADD: begin
        r.entry_start = target;
        if (fn_count >= ENTRIES_DEF) begin
          r.status = ST_FULL;
        end else begin
          fn_start[fn_count] = target;
          fn_len[fn_count] = len;
          r.status = ST_ADDED;
          r.entry_index = 12'(fn_count);
          fn_count++;
        end
      end
      KIND_CALL: begin
        for (int i = 0; i < fn_count && hit < 0; i++)
          if (fn_start[i] == target) hit = i;
      end
      KIND_RET: begin
        // offset is signed 32-bit: must be positive and within the length
        for (int i = 0; i < fn_count && hit < 0; i++) begin
          d = pc - fn_start[i];
          if (d != '0 && !d[31] && d <= {1'b0, fn_len[i]}) hit = i;
        end
      end
      default: ;
    endcase
    if (hit >= 0) begin
      r.entry_index = 12'(hit);
      r.entry_start = fn_start[hit];
      if (kind == KIND_CALL) begin
        r.status = ST_CALL;
        if (call_level < MAX_DEPTH_DEF) call_level++;
      end else begin
        r.status = ST_RET;
        if (call_level > 0) call_level--;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns result %0d: %s", $time, results_seen, msg);
    fault_count++;
  endtask

  task automatic compare_field(string name, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic offer(kind_t kind, logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] target,
                       logic [LEN_W-1:0] len, logic typed, result_t want);
    result_t predicted;
    int      gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {1'b0, len, target, pc};
    do @(posedge clk); while (!s_axis_tready);
    predicted = trace_event(kind, pc, target, len);
    pending_traces.push_back(typed ? want : predicted);
    if ($urandom_range(0, 24) == 0) src_calm = !src_calm;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly calls and returns aimed at known entries, some adds, some noise
  task automatic random_item();
    int unsigned       pick;
    int unsigned       sel;
    kind_t             kind;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] off;
    logic [LEN_W-1:0]  len;
    pick = $urandom_range(0, 99);
    pc = $urandom;
    target = $urandom;
    len = 31'($urandom);
    sel = (fn_count > 0) ? $urandom_range(0, fn_count - 1) : 0;
    if (pick < 20) begin
      kind = KIND_ADD;
      case ($urandom_range(0, 9))
        0: len = '0;
        1: len = '1;
        2, 3: ;
        default: len = 31'($urandom_range(1, 255));
      endcase
    end else if (pick < 57) begin
      kind = KIND_CALL;
      if (fn_count > 0 && $urandom_range(0, 4) != 0) target = fn_start[sel];
    end else if (pick < 94) begin
      kind = KIND_RET;
      if (fn_count > 0 && $urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 3))
          0: off = '0;
          1: off = {1'b0, fn_len[sel]} + 1;
          default: off = $urandom_range(1, {1'b0, fn_len[sel]});
        endcase
        pc = fn_start[sel] + off;
      end
    end else begin
      kind = KIND_NOP;
    end
    offer(kind, pc, target, len, 1'b0, '0);
  endtask

  task automatic wait_drained();
    while (pending_traces.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_traces.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, status %h tdata %h",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        want = pending_traces.pop_front();
        compare_field("status", 32'(m_axis_tuser), 32'(want.status));
        compare_field("entry_index", 32'(m_axis_tdata[11:0]), 32'(want.entry_index));
        compare_field("depth_before", 32'(m_axis_tdata[19:12]), 32'(want.depth_before));
        compare_field("entry_start", m_axis_tdata[51:20], want.entry_start);
        compare_field("pc_out", m_axis_tdata[83:52], want.pc_out);
        compare_field("pad", 32'(m_axis_tdata[87:84]), '0);
      end
      results_seen++;
    end
  end

  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      // one long back-pressure stretch so the input side fills and stalls
      if (!hold_done && results_seen >= 50) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) snk_calm = !snk_calm;
      gap = pick_gap(snk_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    plan_row_t row;
    result_t   want;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = PLAN[i];
      want = '{status: row.status, entry_index: row.index, depth_before: row.depth,
               entry_start: row.start, pc_out: row.pc};
      offer(row.kind, row.pc, row.target, row.length, row.typed, want);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    repeat (110) random_item();

    // four calls through entry 0, then three returns through entry 1
    repeat (4) offer(KIND_CALL, $urandom, 32'h0, 31'($urandom), 1'b0, '0);
    repeat (3) offer(KIND_RET, 32'h0, $urandom, 31'($urandom), 1'b0, '0);
    offer(KIND_NOP, $urandom, $urandom, 31'($urandom), 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (4200) @(posedge clk);
    if (fault_count == 0)
      $display("call_return_trace_table_tb passed");
    else
      $display("call_return_trace_table_tb failed");
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("call_return_trace_table_tb failed");
    $finish;
  end

endmodule
